// ----- rtl/core/u8sc_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sc_pkg: shared types, constants and sequence judge for the UTF-8 sanitizer
// Holds the byte-class bounds, the result beat layout and the
// combinational judge that rules on the piece at the head of the window.
// ----------------------------------------------------------------------------
package u8sc_pkg;

   // byte class bounds
   localparam logic [7:0] PrintLo   = 8'h20;
   localparam logic [7:0] DelChar   = 8'h7f;
   localparam logic [7:0] Lead2Lo   = 8'hc2;
   localparam logic [7:0] Lead2Hi   = 8'hdf;
   localparam logic [7:0] Lead3Lo   = 8'he0;
   localparam logic [7:0] Lead3Hi   = 8'hef;
   localparam logic [7:0] Lead4Lo   = 8'hf0;
   localparam logic [7:0] Lead4Hi   = 8'hf4;
   localparam logic [7:0] AsciiTop  = 8'h80;
   localparam logic [7:0] ReplChar  = 8'h3f;   // '?'

   // code point bounds
   localparam logic [20:0] CpMax    = 21'h10ffff;
   localparam logic [20:0] SurrLo   = 21'h00d800;
   localparam logic [20:0] SurrHi   = 21'h00dfff;
   localparam logic [20:0] C1Lo     = 21'h000080;
   localparam logic [20:0] C1Hi     = 21'h00009f;
   localparam logic [20:0] Min2     = 21'h000080;
   localparam logic [20:0] Min3     = 21'h000800;
   localparam logic [20:0] Min4     = 21'h010000;

   localparam logic [1:0] ContTag   = 2'b10;

   // one result beat
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        byte_present;
      logic        last_of_text;
      logic        was_truncated;
      logic [15:0] bytes_written;
   } u8sc_rsp_type;

   // verdict on the piece at the head of the window
   typedef struct packed {
      logic       hold;   // more bytes needed before a ruling
      logic [2:0] len;    // valid sequence length, 0 = reject one byte
   } u8sc_judge_type;

   function automatic u8sc_judge_type u8sc_judge(
      input logic [7:0] b0,
      input logic [7:0] b1,
      input logic [7:0] b2,
      input logic [7:0] b3,
      input logic [2:0] avail,
      input logic       at_end
   );
      logic [2:0]     need;
      logic [20:0]    cp;
      logic [20:0]    lo;
      logic           cont_ok;
      logic           bad;
      u8sc_judge_type j;

      priority if (b0 >= Lead2Lo && b0 <= Lead2Hi) begin
         need = 3'd2;
      end else if (b0 >= Lead3Lo && b0 <= Lead3Hi) begin
         need = 3'd3;
      end else if (b0 >= Lead4Lo && b0 <= Lead4Hi) begin
         need = 3'd4;
      end else begin
         need = 3'd1;
      end

      unique case (need)
         3'd2: begin
            cp = {10'd0, b0[4:0], b1[5:0]};
            lo = Min2;
         end
         3'd3: begin
            cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            lo = Min3;
         end
         3'd4: begin
            cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            lo = Min4;
         end
         default: begin
            cp = '0;
            lo = '0;
         end
      endcase

      cont_ok = (b1[7:6] == ContTag)
             && (need < 3'd3 || b2[7:6] == ContTag)
             && (need < 3'd4 || b3[7:6] == ContTag);

      bad = (need == 3'd1) || (need > avail) || !cont_ok
         || (cp < lo) || (cp > CpMax)
         || (cp >= SurrLo && cp <= SurrHi)
         || (cp >= C1Lo && cp <= C1Hi);

      j.hold = (need > avail) && !at_end;
      if (b0 < AsciiTop) begin
         j.len = (b0 >= PrintLo && b0 != DelChar) ? 3'd1 : 3'd0;
      end else if (bad) begin
         j.len = 3'd0;
      end else begin
         j.len = need;
      end
      return j;
   endfunction

endpackage

// ----- rtl/core/utf8_sanitize_copy.sv -----
// ----------------------------------------------------------------------------
// utf8_sanitize_copy: streaming UTF-8 sanitizer with capacity limit
// A byte accepted passes through the window (hold_ff) and the output register before its first result beat shows.
// Throughput: one result beat per cycle while the skid register is empty; plain ASCII takes one byte per cycle.
// Reset (synchronous, active high) clears window, counters, flag and capacity.
// ----------------------------------------------------------------------------
//
// Structure
//   - A four-byte window (hold_ff) keeps up to three lookahead bytes plus the
//     newest one. A working cycle judges the piece at the head of the
//     window, emits at most one result beat and shifts the window by one when it emits.
//   - A valid multi-byte sequence is judged once at its lead; its remaining
//     bytes then stream out under pass_ff without a second ruling.
//   - The last-of-text mark has to land on the final beat of the text. In an
//     end-of-text step a second judge looks at the piece after the one being
//     emitted: if the window runs dry, or that piece would not fit, this beat
//     is the final one (and carries the truncated flag in the second case).
//   - Results go to an output register backed by one skid register, so the
//     input side never waits on rsp_ready combinationally. A step may emit
//     up to four beats; the input stalls for the extra cycles of such a
//     step, and takes the next byte in the cycle the step finishes.
//   - Once truncated, bytes of the rest of the text are accepted and dropped;
//     the end-of-text byte then yields one status-only beat.
//   - The capacity register is written through csr_wr_en/csr_wr_data.

`default_nettype none

module utf8_sanitize_copy (
   input  wire logic        clock,
   input  wire logic        reset,

   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,

   // input beats
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,

   // result beats
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_byte_present,
   output      logic        rsp_last_of_text,
   output      logic        rsp_was_truncated,
   output      logic [15:0] rsp_bytes_written
);

   // ---------------------------------------------------------------- state
   logic [7:0]  hold_ff [4];      // byte window, head at index 0
   logic [7:0]  hold_in [4];
   logic [2:0]  cnt_ff, cnt_in;   // bytes in the window
   logic [1:0]  pass_ff, pass_in; // sequence bytes still to stream out
   logic        act_ff, act_in;   // a step is in progress
   logic        eot_ff, eot_in;   // the step in progress ends the text
   logic        trunc_ff, trunc_in;
   logic [15:0] used_ff, used_in;
   logic [15:0] cap_ff;

   // output register + skid
   logic                  out_vld_ff, out_vld_in;
   logic                  skid_vld_ff, skid_vld_in;
   u8sc_pkg::u8sc_rsp_type out_ff, out_in;
   u8sc_pkg::u8sc_rsp_type skid_ff, skid_in;

   // ---------------------------------------------------------------- step logic
   u8sc_pkg::u8sc_judge_type jc;  // piece at the head
   u8sc_pkg::u8sc_judge_type jn;  // piece after one shift (final-beat check)

   logic        can_emit;
   logic        go;
   logic [2:0]  cnt_sh;
   logic [15:0] used_plus;
   logic [2:0]  size_c, size_n;
   logic        over_c, over_n;
   logic        stop_n;
   logic        emit_now;
   logic [7:0]  emit_byte;
   logic [1:0]  pass_after;
   logic        produce;
   logic        step_done;
   logic        accept;
   u8sc_pkg::u8sc_rsp_type res;

   assign can_emit  = !skid_vld_ff;
   assign go        = act_ff && can_emit;
   assign cnt_sh    = cnt_ff - 3'd1;
   assign used_plus = used_ff + 16'd1;

   assign jc = u8sc_pkg::u8sc_judge(hold_ff[0], hold_ff[1], hold_ff[2], hold_ff[3],
                                    cnt_ff, eot_ff);
   assign jn = u8sc_pkg::u8sc_judge(hold_ff[1], hold_ff[2], hold_ff[3], 8'h00,
                                    cnt_sh, 1'b1);

   // a rejected byte still costs one output byte
   assign size_c = (jc.len == 3'd0) ? 3'd1 : jc.len;
   assign size_n = (jn.len == 3'd0) ? 3'd1 : jn.len;

   // used + size > capacity, also covers capacity rewritten below used
   assign over_c = ({2'b00, used_ff} + {15'd0, size_c}) > {2'b00, cap_ff};
   assign over_n = ({2'b00, used_plus} + {15'd0, size_n}) > {2'b00, cap_ff};

   // nothing more comes out of an end-of-text step after this beat
   assign stop_n = (cnt_sh == 3'd0) || over_n;

   always_comb begin
      hold_in    = hold_ff;
      cnt_in     = cnt_ff;
      pass_in    = pass_ff;
      trunc_in   = trunc_ff;
      used_in    = used_ff;
      eot_in     = eot_ff;
      act_in     = act_ff;
      emit_now   = 1'b0;
      emit_byte  = hold_ff[0];
      pass_after = 2'd0;
      produce    = 1'b0;
      step_done  = 1'b0;
      res        = '0;

      if (go) begin
         if (pass_ff != 2'd0) begin
            // tail of an already judged sequence
            emit_now   = 1'b1;
            pass_after = pass_ff - 2'd1;
         end else if (trunc_ff || cnt_ff == 3'd0) begin
            // only reached at end of text after truncation: status beat
            step_done = 1'b1;
            if (eot_ff) begin
               produce           = 1'b1;
               res.last_of_text  = 1'b1;
               res.was_truncated = trunc_ff;
               res.bytes_written = used_ff;
               cnt_in            = 3'd0;
               used_in           = '0;
               trunc_in          = 1'b0;
            end
         end else if (jc.hold) begin
            // lead waits for its continuation bytes
            step_done = 1'b1;
         end else if (over_c) begin
            // next piece does not fit: drop the rest of the text
            step_done = 1'b1;
            cnt_in    = 3'd0;
            trunc_in  = 1'b1;
            if (eot_ff) begin
               produce           = 1'b1;
               res.last_of_text  = 1'b1;
               res.was_truncated = 1'b1;
               res.bytes_written = used_ff;
               used_in           = '0;
               trunc_in          = 1'b0;
            end
         end else begin
            emit_now   = 1'b1;
            emit_byte  = (jc.len == 3'd0) ? u8sc_pkg::ReplChar : hold_ff[0];
            pass_after = (jc.len == 3'd0) ? 2'd0 : 2'(jc.len - 3'd1);
         end

         if (emit_now) begin
            produce           = 1'b1;
            res.out_byte      = emit_byte;
            res.byte_present  = 1'b1;
            res.bytes_written = used_plus;
            hold_in[0]        = hold_ff[1];
            hold_in[1]        = hold_ff[2];
            hold_in[2]        = hold_ff[3];
            cnt_in            = cnt_sh;
            used_in           = used_plus;
            pass_in           = pass_after;
            if (pass_after == 2'd0) begin
               if (eot_ff) begin
                  if (stop_n) begin
                     res.last_of_text  = 1'b1;
                     res.was_truncated = (cnt_sh != 3'd0);
                     step_done         = 1'b1;
                     cnt_in            = 3'd0;
                     used_in           = '0;
                     trunc_in          = 1'b0;
                  end
               end else if (cnt_sh == 3'd0) begin
                  step_done = 1'b1;
               end
            end
         end

         if (step_done) begin
            act_in = 1'b0;
         end
      end

      // new byte joins the window in the cycle the previous step finishes
      req_ready = !act_ff || step_done;
      accept    = req_valid && req_ready;
      if (accept) begin
         eot_in = req_end_of_text;
         if (trunc_in) begin
            // truncated text: drop the byte, only its end needs a beat
            act_in = req_end_of_text;
         end else begin
            hold_in[cnt_in[1:0]] = req_text_byte;
            cnt_in               = cnt_in + 3'd1;
            act_in               = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- output stage
   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (!out_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = res;
            out_vld_in = produce;
         end
      end else if (produce) begin
         skid_in     = res;
         skid_vld_in = 1'b1;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_out_byte      = out_ff.out_byte;
   assign rsp_byte_present  = out_ff.byte_present;
   assign rsp_last_of_text  = out_ff.last_of_text;
   assign rsp_was_truncated = out_ff.was_truncated;
   assign rsp_bytes_written = out_ff.bytes_written;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         pass_ff     <= '0;
         act_ff      <= 1'b0;
         eot_ff      <= 1'b0;
         trunc_ff    <= 1'b0;
         used_ff     <= '0;
         cap_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         pass_ff     <= pass_in;
         act_ff      <= act_in;
         eot_ff      <= eot_in;
         trunc_ff    <= trunc_in;
         used_ff     <= used_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // ---------------------------------------------------------------- assertions
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a beat while the output register is empty");

   a_idle_window: assert property (@(posedge clock) disable iff (reset)
      !act_ff |-> (pass_ff == 2'd0 && cnt_ff <= 3'd3))
      else $error("idle with a sequence in flight or an overfull window");

   a_pass_in_window: assert property (@(posedge clock) disable iff (reset)
      pass_ff != 2'd0 |-> ({1'b0, pass_ff} <= cnt_ff))
      else $error("sequence tail not held in the window");

   a_trunc_empty: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |-> cnt_ff == 3'd0)
      else $error("window holds bytes after truncation");

endmodule

`default_nettype wire
